// ===== hdl/bwt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the breakpoint/watchpoint trigger unit.
// No dependencies; imported by the cell modules and the top level.
package bwt_pkg;

  localparam int unsigned ADDR_FIELD_W = 32;
  localparam int unsigned LEN_FIELD_W  = 16;

  typedef enum logic [3:0] {
    ACT_FETCH        = 4'd0,
    ACT_READ         = 4'd1,
    ACT_WRITE        = 4'd2,
    ACT_ADD_BP       = 4'd3,
    ACT_REMOVE_BP    = 4'd4,
    ACT_CLEAR_BP     = 4'd5,
    ACT_ADD_WATCH    = 4'd6,
    ACT_REMOVE_WATCH = 4'd7,
    ACT_CLEAR_WATCH  = 4'd8,
    ACT_ARM_SKIP     = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    WK_READ  = 2'd0,
    WK_WRITE = 2'd1,
    WK_ANY   = 2'd2
  } watch_kind_e;

  localparam logic REASON_BP = 1'b0;
  localparam logic REASON_WP = 1'b1;

  typedef enum logic [2:0] {
    BP_FETCH  = 3'd0,
    BP_PROBE  = 3'd1,
    BP_PLACE  = 3'd2,
    BP_REMOVE = 3'd3,
    BP_CLEAR  = 3'd4
  } bp_op_e;

  typedef enum logic [1:0] {
    WP_CHECK  = 2'd0,
    WP_ADD    = 2'd1,
    WP_REMOVE = 2'd2,
    WP_CLEAR  = 2'd3
  } wp_op_e;

  typedef struct packed {
    logic   vld;
    bp_op_e op;
    logic   suppress;
    logic   found;
    logic   placed;
  } bp_ctl_t;

  typedef struct packed {
    logic       vld;
    wp_op_e     op;
    logic [1:0] kind;
    logic       found;
    logic       placed;
  } wp_ctl_t;

  typedef struct packed {
    logic [3:0]              action;
    logic [ADDR_FIELD_W-1:0] address;
    logic [LEN_FIELD_W-1:0]  length;
    logic [1:0]              watch_kind;
  } trig_in_t;

  typedef struct packed {
    logic                    hit;
    logic                    hit_reason;
    logic [ADDR_FIELD_W-1:0] hit_address;
    logic                    table_full;
  } trig_out_t;

endpackage

// ===== hdl/bwt_bp_cell.sv =====
`timescale 1ns / 1ps
// One breakpoint cell: holds one address entry and passes the command beat on.
// Depends on bwt_pkg.
module bwt_bp_cell import bwt_pkg::*; #(
  parameter int unsigned AW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bp_ctl_t       ctl_i,
  input  logic [AW-1:0] addr_i,
  output bp_ctl_t       ctl_o,
  output logic [AW-1:0] addr_o
);

  logic          ent_vld_q, ent_vld_d;
  logic [AW-1:0] ent_addr_q;
  logic          ent_wr;
  logic          match;
  bp_ctl_t       ctl_q, ctl_d;
  logic [AW-1:0] addr_q;

  always_comb begin
    match     = ent_vld_q && (ent_addr_q == addr_i);
    ctl_d     = ctl_i;
    ent_vld_d = ent_vld_q;
    ent_wr    = 1'b0;
    if (ctl_i.vld) begin
      unique case (ctl_i.op)
        BP_FETCH: begin
          if (match && !ctl_i.suppress) ctl_d.found = 1'b1;
        end
        BP_PROBE: begin
          if (match) ctl_d.found = 1'b1;
        end
        BP_PLACE: begin
          if (!ent_vld_q && !ctl_i.placed) begin
            ent_vld_d    = 1'b1;
            ent_wr       = 1'b1;
            ctl_d.placed = 1'b1;
          end
        end
        BP_REMOVE: begin
          if (match) ent_vld_d = 1'b0;
        end
        BP_CLEAR: begin
          ent_vld_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      ctl_q     <= '0;
    end else begin
      ent_vld_q <= ent_vld_d;
      ctl_q     <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_wr) ent_addr_q <= addr_i;
    addr_q <= addr_i;
  end

  assign ctl_o  = ctl_q;
  assign addr_o = addr_q;

endmodule

// ===== hdl/bwt_wp_cell.sv =====
`timescale 1ns / 1ps
// One watchpoint cell: holds one watch range and passes the command beat on.
// Depends on bwt_pkg.
module bwt_wp_cell import bwt_pkg::*; #(
  parameter int unsigned AW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wp_ctl_t       ctl_i,
  input  logic [AW-1:0] addr_i,
  input  logic [AW-1:0] aux_i,
  output wp_ctl_t       ctl_o,
  output logic [AW-1:0] addr_o,
  output logic [AW-1:0] aux_o
);

  logic          ent_vld_q, ent_vld_d;
  logic [AW-1:0] ent_start_q;
  logic [AW-1:0] ent_end_q;
  logic [1:0]    ent_kind_q;
  logic          ent_wr;
  logic          match_start, overlap, kind_ok;
  wp_ctl_t       ctl_q, ctl_d;
  logic [AW-1:0] addr_q, aux_q;

  // aux_i is the wrapped access end on checks and the wrapped watch end on adds
  always_comb begin
    match_start = ent_vld_q && (ent_start_q == addr_i);
    overlap     = (addr_i < ent_end_q) && (ent_start_q < aux_i);
    kind_ok     = (ent_kind_q == ctl_i.kind) || (ent_kind_q == WK_ANY);
    ctl_d       = ctl_i;
    ent_vld_d   = ent_vld_q;
    ent_wr      = 1'b0;
    if (ctl_i.vld) begin
      unique case (ctl_i.op)
        WP_CHECK: begin
          if (ent_vld_q && kind_ok && overlap) ctl_d.found = 1'b1;
        end
        WP_ADD: begin
          if ((!ent_vld_q || match_start) && !ctl_i.placed) begin
            ent_vld_d    = 1'b1;
            ent_wr       = 1'b1;
            ctl_d.placed = 1'b1;
          end else if (match_start) begin
            ent_vld_d = 1'b0;
          end
        end
        WP_REMOVE: begin
          if (match_start) ent_vld_d = 1'b0;
        end
        WP_CLEAR: begin
          ent_vld_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      ctl_q     <= '0;
    end else begin
      ent_vld_q <= ent_vld_d;
      ctl_q     <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_wr) begin
      ent_start_q <= addr_i;
      ent_end_q   <= aux_i;
      ent_kind_q  <= ctl_i.kind;
    end
    addr_q <= addr_i;
    aux_q  <= aux_i;
  end

  assign ctl_o  = ctl_q;
  assign addr_o = addr_q;
  assign aux_o  = aux_q;

endmodule

// ===== hdl/breakpoint_watchpoint_trigger_unit.sv =====
`timescale 1ns / 1ps
// Top level of the debug trigger unit: command decode, skip register, result register
// and the two cell chains. Depends on bwt_pkg, bwt_bp_cell and bwt_wp_cell.
//
//   channel   direction  handshake           payload
//   command   in         start & !busy       cmd_i    (trig_in_t)
//   result    out        done_o, one cycle   result_o (trig_out_t)
//
// A command beat walks the cell chain one cell per cycle.
// Fetch check, remove/clear bp and every watch action take one walk of their chain.
// Add bp takes one walk if already present, else two (probe walk, then place walk).
// Arm skip and unused codes finish without a walk.
// busy is high while a walk is in flight; the result strobe cannot be stalled.
// Reset clears all valid bits and the skip flag at once; no clearing pass.
module breakpoint_watchpoint_trigger_unit import bwt_pkg::*; #(
  parameter int unsigned BP_ENTRIES    = 16,
  parameter int unsigned WATCH_ENTRIES = 8,
  parameter int unsigned ADDR_BITS     = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  trig_in_t  cmd_i,
  output logic      done_o,
  output trig_out_t result_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BP   = 2'd1;
  localparam logic [1:0] S_WP   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  logic [63:0]          cmd_ext;
  logic [ADDR_BITS-1:0] cmd_addr;
  logic [ADDR_BITS-1:0] cmd_end;

  logic                 skip_armed_q, skip_armed_d;
  logic [ADDR_BITS-1:0] skip_addr_q;
  logic                 skip_wr;

  logic      done_q, done_d;
  trig_out_t result_q, result_d;

  bp_ctl_t              bp_launch;
  logic [ADDR_BITS-1:0] bp_launch_addr;
  wp_ctl_t              wp_launch;
  logic [ADDR_BITS-1:0] wp_launch_aux;

  bp_ctl_t              bp_ctl  [BP_ENTRIES+1];
  logic [ADDR_BITS-1:0] bp_addr [BP_ENTRIES+1];
  wp_ctl_t              wp_ctl  [WATCH_ENTRIES+1];
  logic [ADDR_BITS-1:0] wp_addr [WATCH_ENTRIES+1];
  logic [ADDR_BITS-1:0] wp_aux  [WATCH_ENTRIES+1];

  bp_ctl_t              bp_tail;
  wp_ctl_t              wp_tail;
  logic [63:0]          bp_tail_ext;
  logic [63:0]          wp_tail_ext;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign cmd_ext  = 64'(cmd_i.address);
  assign cmd_addr = cmd_ext[ADDR_BITS-1:0];
  assign cmd_end  = cmd_addr + ADDR_BITS'(cmd_i.length);

  assign bp_tail     = bp_ctl[BP_ENTRIES];
  assign wp_tail     = wp_ctl[WATCH_ENTRIES];
  assign bp_tail_ext = 64'(bp_addr[BP_ENTRIES]);
  assign wp_tail_ext = 64'(wp_addr[WATCH_ENTRIES]);

  always_comb begin
    state_d        = state_q;
    skip_armed_d   = skip_armed_q;
    skip_wr        = 1'b0;
    done_d         = 1'b0;
    result_d       = '0;
    bp_launch      = '0;
    bp_launch_addr = cmd_addr;
    wp_launch      = '0;
    wp_launch_aux  = cmd_end;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_e'(cmd_i.action)) inside
            ACT_FETCH: begin
              bp_launch.vld      = 1'b1;
              bp_launch.op       = BP_FETCH;
              bp_launch.suppress = skip_armed_q && (skip_addr_q == cmd_addr);
              skip_armed_d       = 1'b0;
              state_d            = S_BP;
            end
            ACT_READ, ACT_WRITE: begin
              wp_launch.vld  = 1'b1;
              wp_launch.op   = WP_CHECK;
              wp_launch.kind = (action_e'(cmd_i.action) == ACT_READ) ? WK_READ : WK_WRITE;
              state_d        = S_WP;
            end
            ACT_ADD_BP: begin
              bp_launch.vld = 1'b1;
              bp_launch.op  = BP_PROBE;
              state_d       = S_BP;
            end
            ACT_REMOVE_BP: begin
              bp_launch.vld = 1'b1;
              bp_launch.op  = BP_REMOVE;
              state_d       = S_BP;
            end
            ACT_CLEAR_BP: begin
              bp_launch.vld = 1'b1;
              bp_launch.op  = BP_CLEAR;
              state_d       = S_BP;
            end
            ACT_ADD_WATCH: begin
              wp_launch.vld  = 1'b1;
              wp_launch.op   = WP_ADD;
              wp_launch.kind = cmd_i.watch_kind;
              state_d        = S_WP;
            end
            ACT_REMOVE_WATCH: begin
              wp_launch.vld = 1'b1;
              wp_launch.op  = WP_REMOVE;
              state_d       = S_WP;
            end
            ACT_CLEAR_WATCH: begin
              wp_launch.vld = 1'b1;
              wp_launch.op  = WP_CLEAR;
              state_d       = S_WP;
            end
            ACT_ARM_SKIP: begin
              skip_armed_d = 1'b1;
              skip_wr      = 1'b1;
              done_d       = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_BP: begin
        bp_launch_addr = bp_addr[BP_ENTRIES];
        if (bp_tail.vld) begin
          unique case (bp_tail.op)
            BP_FETCH: begin
              done_d               = 1'b1;
              state_d              = S_IDLE;
              result_d.hit         = bp_tail.found;
              result_d.hit_reason  = REASON_BP;
              result_d.hit_address = bp_tail.found ? bp_tail_ext[ADDR_FIELD_W-1:0] : '0;
            end
            BP_PROBE: begin
              if (bp_tail.found) begin
                done_d  = 1'b1;
                state_d = S_IDLE;
              end else begin
                bp_launch.vld = 1'b1;
                bp_launch.op  = BP_PLACE;
              end
            end
            BP_PLACE: begin
              done_d              = 1'b1;
              state_d             = S_IDLE;
              result_d.table_full = !bp_tail.placed;
            end
            default: begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_WP: begin
        if (wp_tail.vld) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          unique case (wp_tail.op)
            WP_CHECK: begin
              result_d.hit         = wp_tail.found;
              result_d.hit_reason  = wp_tail.found ? REASON_WP : REASON_BP;
              result_d.hit_address = wp_tail.found ? wp_tail_ext[ADDR_FIELD_W-1:0] : '0;
            end
            WP_ADD: begin
              result_d.table_full = !wp_tail.placed;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      skip_armed_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      skip_armed_q <= skip_armed_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skip_wr) skip_addr_q <= cmd_addr;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  assign bp_ctl[0]  = bp_launch;
  assign bp_addr[0] = bp_launch_addr;
  assign wp_ctl[0]  = wp_launch;
  assign wp_addr[0] = cmd_addr;
  assign wp_aux[0]  = wp_launch_aux;

  for (genvar i = 0; i < BP_ENTRIES; i++) begin : g_bp
    bwt_bp_cell #(
      .AW(ADDR_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (bp_ctl[i]),
      .addr_i(bp_addr[i]),
      .ctl_o (bp_ctl[i+1]),
      .addr_o(bp_addr[i+1])
    );
  end

  for (genvar i = 0; i < WATCH_ENTRIES; i++) begin : g_wp
    bwt_wp_cell #(
      .AW(ADDR_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (wp_ctl[i]),
      .addr_i(wp_addr[i]),
      .aux_i (wp_aux[i]),
      .ctl_o (wp_ctl[i+1]),
      .addr_o(wp_addr[i+1]),
      .aux_o (wp_aux[i+1])
    );
  end

`ifndef SYNTHESIS
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result beat without a command in flight");

  a_miss_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.hit) |-> (!result_o.hit_reason && (result_o.hit_address == '0)))
    else $error("miss beat carries reason or address");

  a_full_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.hit && result_o.table_full))
    else $error("hit and table full in one beat");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither walking nor done");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for breakpoint_watchpoint_trigger_unit: directed and random commands.
// Carries its own trigger model in a scoreboard class; depends on bwt_pkg and the RTL.
module tb_top;
  import bwt_pkg::*;

  localparam int BP_N      = 16;
  localparam int WP_N      = 8;
  localparam int ITEM_GOAL = 1600;
  localparam int MAX_LAT   = 2 * BP_N + 8;
  localparam int LIMIT     = 600000;

  localparam logic [3:0] ACT_UNUSED_LO = 4'(ACT_ARM_SKIP) + 4'd1;
  localparam logic [3:0] ACT_UNUSED_HI = 4'hF;
  localparam logic [1:0] WK_NONE       = 2'd3;

  class trigger_scoreboard;
    logic [31:0] bp_addr[BP_N];
    bit          bp_vld[BP_N];
    logic [31:0] wp_start[WP_N];
    logic [15:0] wp_size[WP_N];
    logic [1:0]  wp_kind[WP_N];
    bit          wp_vld[WP_N];
    bit          skip_on;
    logic [31:0] skip_pc;
    trig_out_t   pending_results[$];
    int          errors;

    function new();
      for (int i = 0; i < BP_N; i++) bp_vld[i] = 0;
      for (int i = 0; i < WP_N; i++) wp_vld[i] = 0;
      skip_on = 0;
      skip_pc = '0;
      errors  = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch @%0t: %s", $realtime, msg);
    endfunction

    function void note_command(trig_in_t c);
      trig_out_t   r;
      logic [31:0] a, a_end, w_end;
      logic [1:0]  want;
      bit          hit, why, full, present, suppress;
      hit = 0;
      why = REASON_BP;
      full = 0;
      a = c.address;
      case (c.action)
        ACT_FETCH: begin
          suppress = 0;
          if (skip_on) begin
            skip_on = 0;
            suppress = (skip_pc == a);
          end
          if (!suppress)
            for (int i = 0; i < BP_N; i++)
              if (bp_vld[i] && bp_addr[i] == a) hit = 1;
        end
        ACT_READ, ACT_WRITE: begin
          want = (c.action == ACT_READ) ? WK_READ : WK_WRITE;
          a_end = a + 32'(c.length);
          for (int i = 0; i < WP_N; i++) begin
            w_end = wp_start[i] + 32'(wp_size[i]);
            if (wp_vld[i] && (wp_kind[i] == want || wp_kind[i] == WK_ANY) &&
                a < w_end && wp_start[i] < a_end) begin
              hit = 1;
              why = REASON_WP;
            end
          end
        end
        ACT_ADD_BP: begin
          present = 0;
          for (int i = 0; i < BP_N; i++)
            if (bp_vld[i] && bp_addr[i] == a) present = 1;
          if (!present) begin
            full = 1;
            for (int i = 0; i < BP_N; i++)
              if (full && !bp_vld[i]) begin
                bp_vld[i] = 1;
                bp_addr[i] = a;
                full = 0;
              end
          end
        end
        ACT_REMOVE_BP: begin
          for (int i = 0; i < BP_N; i++)
            if (bp_vld[i] && bp_addr[i] == a) bp_vld[i] = 0;
        end
        ACT_CLEAR_BP: begin
          for (int i = 0; i < BP_N; i++) bp_vld[i] = 0;
        end
        ACT_ADD_WATCH, ACT_REMOVE_WATCH: begin
          for (int i = 0; i < WP_N; i++)
            if (wp_vld[i] && wp_start[i] == a) wp_vld[i] = 0;
          if (c.action == ACT_ADD_WATCH) begin
            full = 1;
            for (int i = 0; i < WP_N; i++)
              if (full && !wp_vld[i]) begin
                wp_vld[i] = 1;
                wp_start[i] = a;
                wp_size[i] = c.length;
                wp_kind[i] = c.watch_kind;
                full = 0;
              end
          end
        end
        ACT_CLEAR_WATCH: begin
          for (int i = 0; i < WP_N; i++) wp_vld[i] = 0;
        end
        ACT_ARM_SKIP: begin
          skip_on = 1;
          skip_pc = a;
        end
        default: ;
      endcase
      r.hit         = hit;
      r.hit_reason  = hit & why;
      r.hit_address = hit ? a : '0;
      r.table_full  = full;
      pending_results = {pending_results, r};
    endfunction

    function void check_result(trig_out_t got);
      trig_out_t exp_r;
      if (pending_results.size() == 0) begin
        report("result beat with no command outstanding");
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.hit !== exp_r.hit)
        report($sformatf("hit %b, want %b", got.hit, exp_r.hit));
      if (got.hit_reason !== exp_r.hit_reason)
        report($sformatf("hit_reason %b, want %b", got.hit_reason, exp_r.hit_reason));
      if (got.hit_address !== exp_r.hit_address)
        report($sformatf("hit_address %h, want %h", got.hit_address, exp_r.hit_address));
      if (got.table_full !== exp_r.table_full)
        report($sformatf("table_full %b, want %b", got.table_full, exp_r.table_full));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  logic      busy;
  trig_in_t  cmd_i;
  logic      done_o;
  trig_out_t result_o;

  trigger_scoreboard sb;
  int          cycles  = 0;
  int          n_items = 0;
  bit          no_gaps = 0;
  logic [31:0] addr_pool[16];

  breakpoint_watchpoint_trigger_unit #(
    .BP_ENTRIES   (BP_N),
    .WATCH_ENTRIES(WP_N),
    .ADDR_BITS    (32)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  task automatic send_cmd(input logic [3:0] act, input logic [31:0] addr,
                          input logic [15:0] len, input logic [1:0] kind);
    trig_in_t c;
    int       gap;
    c.action     = act;
    c.address    = addr;
    c.length     = len;
    c.watch_kind = kind;
    cmd_i <= c;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(c);
    if (act <= ACT_ARM_SKIP) n_items++;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return addr_pool[$urandom_range(0, 15)];
    endcase
  endfunction

  function automatic logic [31:0] near_addr();
    return rand_addr() + 32'($urandom_range(0, 15)) - 32'd8;
  endfunction

  function automatic logic [15:0] rand_len();
    case ($urandom_range(0, 9))
      0: return 16'h0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic refresh_pool();
    for (int i = 0; i < 16; i++)
      addr_pool[i] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + 32'($urandom_range(0, 15))
                                                 : $urandom;
  endtask

  task automatic fill_bp_table();
    logic [31:0] placed[$];
    logic [31:0] a;
    send_cmd(ACT_CLEAR_BP, $urandom, 16'($urandom), 2'($urandom));
    repeat (BP_N + 1 + $urandom_range(0, 2)) begin
      a = ($urandom_range(0, 4) == 0) ? rand_addr() : $urandom;
      placed = {placed, a};
      send_cmd(ACT_ADD_BP, a, 16'($urandom), 2'($urandom));
    end
    repeat (10) begin
      a = placed[$urandom_range(0, placed.size() - 1)];
      case ($urandom_range(0, 4))
        0: send_cmd(ACT_REMOVE_BP, a, 16'($urandom), 2'($urandom));
        1: begin
          send_cmd(ACT_ARM_SKIP, a, 16'($urandom), 2'($urandom));
          send_cmd(ACT_FETCH, a, 16'($urandom), 2'($urandom));
        end
        2: send_cmd(ACT_ADD_BP, a, 16'($urandom), 2'($urandom));
        default: send_cmd(ACT_FETCH, a, 16'($urandom), 2'($urandom));
      endcase
    end
  endtask

  task automatic fill_watch_table();
    logic [31:0] placed[$];
    logic [31:0] a;
    send_cmd(ACT_CLEAR_WATCH, $urandom, 16'($urandom), 2'($urandom));
    repeat (WP_N + 1 + $urandom_range(0, 2)) begin
      a = rand_addr();
      placed = {placed, a};
      send_cmd(ACT_ADD_WATCH, a, rand_len(), 2'($urandom));
    end
    repeat (12) begin
      a = placed[$urandom_range(0, placed.size() - 1)] + 32'($urandom_range(0, 15)) - 32'd8;
      case ($urandom_range(0, 5))
        0: send_cmd(ACT_REMOVE_WATCH, placed[$urandom_range(0, placed.size() - 1)],
                    16'($urandom), 2'($urandom));
        1: send_cmd(ACT_ADD_WATCH, placed[$urandom_range(0, placed.size() - 1)],
                    rand_len(), 2'($urandom));
        2, 3: send_cmd(ACT_READ, a, rand_len(), 2'($urandom));
        default: send_cmd(ACT_WRITE, a, rand_len(), 2'($urandom));
      endcase
    end
  endtask

  task automatic mixed_burst(input int n);
    logic [31:0] a;
    int          r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      a = rand_addr();
      if (r < 25) send_cmd(ACT_FETCH, a, 16'($urandom), 2'($urandom));
      else if (r < 40) send_cmd(ACT_READ, near_addr(), rand_len(), 2'($urandom));
      else if (r < 55) send_cmd(ACT_WRITE, near_addr(), rand_len(), 2'($urandom));
      else if (r < 65) send_cmd(ACT_ADD_BP, a, 16'($urandom), 2'($urandom));
      else if (r < 71) send_cmd(ACT_REMOVE_BP, a, 16'($urandom), 2'($urandom));
      else if (r < 73) send_cmd(ACT_CLEAR_BP, $urandom, 16'($urandom), 2'($urandom));
      else if (r < 83) send_cmd(ACT_ADD_WATCH, a, rand_len(), 2'($urandom));
      else if (r < 88) send_cmd(ACT_REMOVE_WATCH, a, 16'($urandom), 2'($urandom));
      else if (r < 90) send_cmd(ACT_CLEAR_WATCH, $urandom, 16'($urandom), 2'($urandom));
      else if (r < 97) begin
        send_cmd(ACT_ARM_SKIP, a, 16'($urandom), 2'($urandom));
        if ($urandom_range(0, 1)) send_cmd(ACT_FETCH, a, 16'($urandom), 2'($urandom));
      end else
        send_cmd(4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), $urandom,
                 16'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    refresh_pool();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: address edges, skip behavior, wrapped and zero-length ranges
    send_cmd(ACT_FETCH, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_ADD_BP, 32'h0, 16'hFFFF, WK_NONE);
    send_cmd(ACT_ADD_BP, 32'hFFFF_FFFF, 16'h0, WK_READ);
    send_cmd(ACT_ADD_BP, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_FETCH, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_FETCH, 32'hFFFF_FFFF, 16'hFFFF, WK_NONE);
    send_cmd(ACT_ARM_SKIP, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_ARM_SKIP, 32'hFFFF_FFFF, 16'h0, WK_READ);
    send_cmd(ACT_FETCH, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_ARM_SKIP, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_FETCH, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_REMOVE_BP, 32'h1234_5678, 16'h0, WK_READ);
    send_cmd(ACT_REMOVE_BP, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_FETCH, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_ADD_WATCH, 32'hFFFF_FFF0, 16'hFFFF, WK_ANY);
    send_cmd(ACT_READ, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_ADD_WATCH, 32'h1000, 16'h10, WK_READ);
    send_cmd(ACT_WRITE, 32'h1008, 16'h4, WK_READ);
    send_cmd(ACT_READ, 32'h100F, 16'h1, WK_READ);
    send_cmd(ACT_ADD_WATCH, 32'h1000, 16'h20, WK_NONE);
    send_cmd(ACT_READ, 32'h1008, 16'h4, WK_READ);
    send_cmd(ACT_CLEAR_BP, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_REMOVE_WATCH, 32'h1000, 16'h0, WK_READ);
    send_cmd(ACT_CLEAR_WATCH, 32'h0, 16'h0, WK_READ);
    send_cmd(ACT_UNUSED_LO, $urandom, 16'($urandom), 2'($urandom));
    send_cmd(ACT_UNUSED_HI, $urandom, 16'($urandom), 2'($urandom));

    while (n_items < ITEM_GOAL) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) refresh_pool();
      case ($urandom_range(0, 9))
        0: fill_bp_table();
        1: fill_watch_table();
        2: repeat (5)
          send_cmd(4'($urandom), $urandom, 16'($urandom), 2'($urandom));
        default: mixed_burst(20);
      endcase
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (MAX_LAT) @(posedge clk_i);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/bwt_pkg.sv
hdl/bwt_bp_cell.sv
hdl/bwt_wp_cell.sv
hdl/breakpoint_watchpoint_trigger_unit.sv
sim/tb_top.sv
